// ===== sv/pseg_pkg.sv =====
// Package for the palette shade entry generator.
// Shared constants, register and format codes, and the lighting unit's
// request/response structs. No dependencies.
`default_nettype none

package pseg_pkg;

  localparam int DefaultPaletteDepth = 256;

  localparam int ChanW    = 8;
  localparam int ShadesW  = 9;
  localparam int EntryW   = 24;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 9;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgNumShades   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgDestBase    = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgDestRange   = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgOutputFormat = CfgIdxW'(3);

  localparam logic [1:0] FmtIndex  = 2'd0;
  localparam logic [1:0] FmtRgb555 = 2'd1;
  localparam logic [1:0] FmtRgb565 = 2'd2;
  localparam logic [1:0] FmtRgb888 = 2'd3;

  localparam logic [ShadesW-1:0] ResetNumShades  = 9'd64;
  localparam logic [7:0]         ResetDestBase   = 8'd0;
  localparam logic [ShadesW-1:0] ResetDestRange  = 9'd256;

  localparam logic [7:0] EmptySearchIndex = 8'd127;
  localparam int         SearchLimit      = 255;

  typedef struct packed {
    logic               valid;
    logic [ChanW-1:0]   red;
    logic [ChanW-1:0]   green;
    logic [ChanW-1:0]   blue;
    logic [ChanW-1:0]   level;
    logic [ShadesW-1:0] shades;
  } light_req_t;

  typedef struct packed {
    logic             done;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } light_rsp_t;

endpackage

`default_nettype wire

// ===== sv/pseg_light.sv =====
// Lighting unit: one product per channel, then an 8-step restoring divide
// shared by three channel lanes. Depends on pseg_pkg.
`default_nettype none

module pseg_light (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pseg_pkg::light_req_t req_i,
  output pseg_pkg::light_rsp_t      rsp_o
);

  localparam logic [1:0] LIdle = 2'd0;
  localparam logic [1:0] LMul  = 2'd1;
  localparam logic [1:0] LDiv  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        done_q, done_d;

  logic [7:0]  chan_q [3];
  logic [7:0]  level_q;
  logic [8:0]  shades_q;
  logic [17:0] rem_q [3];
  logic [17:0] rem_d [3];
  logic [7:0]  quo_q [3];
  logic [7:0]  quo_d [3];
  logic [17:0] dsh_q, dsh_d;

  logic [9:0]  level4;
  logic [10:0] shades3;
  logic        low_ramp;
  logic [7:0]  ramp_diff;
  logic [15:0] prod_lo [3];
  logic [15:0] prod_hi [3];
  logic [7:0]  lit_chan [3];

  assign level4    = {level_q, 2'b00};
  assign shades3   = {1'b0, shades_q, 1'b0} + {2'b00, shades_q};
  assign low_ramp  = {1'b0, level4} < shades3;
  // upper ramp: 4s - 3T < T, so the low byte holds the whole difference
  assign ramp_diff = level4[7:0] - shades3[7:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_lo[i] = level_q * chan_q[i];
      prod_hi[i] = ramp_diff * (8'd255 - chan_q[i]);
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    dsh_d   = dsh_q;
    for (int i = 0; i < 3; i++) begin
      rem_d[i] = rem_q[i];
      quo_d[i] = quo_q[i];
    end
    unique case (state_q)
      LIdle: begin
        if (req_i.valid) begin
          state_d = LMul;
        end
      end
      LMul: begin
        dsh_d = low_ramp ? {shades3, 7'd0} : {1'b0, 1'b0, shades_q, 7'd0};
        for (int i = 0; i < 3; i++) begin
          rem_d[i] = low_ramp ? {prod_lo[i], 2'b00} : {2'b00, prod_hi[i]};
          quo_d[i] = '0;
        end
        cnt_d   = '0;
        state_d = LDiv;
      end
      LDiv: begin
        for (int i = 0; i < 3; i++) begin
          if (rem_q[i] >= dsh_q) begin
            rem_d[i] = rem_q[i] - dsh_q;
            quo_d[i] = {quo_q[i][6:0], 1'b1};
          end else begin
            quo_d[i] = {quo_q[i][6:0], 1'b0};
          end
        end
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          done_d  = 1'b1;
          state_d = LIdle;
        end
      end
      default: begin
        state_d = LIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == LIdle && req_i.valid) begin
      chan_q[0] <= req_i.red;
      chan_q[1] <= req_i.green;
      chan_q[2] <= req_i.blue;
      level_q   <= req_i.level;
      shades_q  <= req_i.shades;
    end
    dsh_q <= dsh_d;
    for (int i = 0; i < 3; i++) begin
      rem_q[i] <= rem_d[i];
      quo_q[i] <= quo_d[i];
    end
  end

  // upper ramp adds the source channel back
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lit_chan[i] = low_ramp ? quo_q[i] : quo_q[i] + chan_q[i];
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.red   = lit_chan[0];
  assign rsp_o.green = lit_chan[1];
  assign rsp_o.blue  = lit_chan[2];

endmodule

`default_nettype wire

// ===== sv/palette_shade_entry_generator.sv =====
// Top level: config registers, palette memory, nearest-color scan, packing.
// Depends on pseg_pkg and pseg_light.
// Load: written on accept if the index is inside the palette, no result. Out-of-range query: result in the next cycle.
// Packed-color or empty-search query: result once pseg_light finishes its 8-step divide.
// Index query: divide, then N entries scanned at one read per cycle, then pipeline drain.
// One item at a time, busy high until the result cycle; results cannot be stalled.
// Reset returns control to idle and config registers to their defaults; palette contents undefined.
`default_nettype none

module palette_shade_entry_generator #(
  parameter int PALETTE_DEPTH = pseg_pkg::DefaultPaletteDepth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic                          operation_i,
  input  wire logic [7:0]                    palette_index_i,
  input  wire logic [7:0]                    red_i,
  input  wire logic [7:0]                    green_i,
  input  wire logic [7:0]                    blue_i,
  input  wire logic [7:0]                    shade_level_i,
  output      logic                          result_valid_o,
  output      logic [23:0]                   entry_value_o,
  output      logic                          status_o,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [pseg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [pseg_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int AddrW = $clog2(PALETTE_DEPTH);
  localparam int SearchLast = (PALETTE_DEPTH - 1 < pseg_pkg::SearchLimit) ?
                              PALETTE_DEPTH - 1 : pseg_pkg::SearchLimit;
  localparam logic [7:0] SearchLastIdx = 8'(SearchLast);

  localparam logic [1:0] SIdle  = 2'd0;
  localparam logic [1:0] SLight = 2'd1;
  localparam logic [1:0] SScan  = 2'd2;
  localparam logic [1:0] SDrain = 2'd3;

  // config registers
  logic [8:0] shade_cnt_q;
  logic [7:0] dest_base_q;
  logic [8:0] dest_range_q;
  logic [1:0] output_format_q;

  // control
  logic [1:0]  state_q, state_d;
  logic [7:0]  scan_idx_q, scan_idx_d;
  logic [7:0]  stop_idx_q, stop_idx_d;
  logic        p1_v_q, p2_v_q;
  logic [7:0]  p1_idx_q, p2_idx_q;
  logic        found_q;
  logic [17:0] best_d_q;
  logic [7:0]  best_q;
  logic        res_valid_q, res_valid_d;
  logic [23:0] res_value_q, res_value_d;
  logic        res_status_q, res_status_d;

  // lit color
  logic [7:0]  lit_q [3];

  // palette memory
  logic [23:0]      mem_q [PALETTE_DEPTH];
  logic [23:0]      rdata_q;
  logic             wr_en;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;

  logic                 accept;
  logic                 level_ok;
  pseg_pkg::light_req_t light_req;
  pseg_pkg::light_rsp_t light_rsp;

  logic [9:0]  end_sum;
  logic        search_empty;
  logic [7:0]  search_stop;
  logic [23:0] packed_value;

  logic signed [8:0]  diff [3];
  logic signed [17:0] sqr [3];
  logic [15:0]        sq_q [3];
  logic [17:0]        dist_sum;

  assign busy        = state_q != SIdle;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign level_ok    = {1'b0, shade_level_i} < shade_cnt_q;

  assign wr_en   = accept && operation_i == pseg_pkg::OpLoad &&
                   32'(palette_index_i) < PALETTE_DEPTH;
  assign rd_en   = state_q == SScan;
  assign rd_addr = AddrW'(scan_idx_q);

  assign light_req.valid  = accept && operation_i == pseg_pkg::OpQuery && level_ok;
  assign light_req.red    = red_i;
  assign light_req.green  = green_i;
  assign light_req.blue   = blue_i;
  assign light_req.level  = shade_level_i;
  assign light_req.shades = shade_cnt_q;

  pseg_light u_light (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (light_req),
    .rsp_o  (light_rsp)
  );

  // search window
  assign end_sum      = {2'b00, dest_base_q} + {1'b0, dest_range_q} - 10'd1;
  assign search_empty = dest_range_q == 9'd0 || dest_base_q > SearchLastIdx;
  assign search_stop  = (end_sum > {2'b00, SearchLastIdx}) ? SearchLastIdx : end_sum[7:0];

  always_comb begin
    unique case (output_format_q)
      pseg_pkg::FmtRgb555: packed_value = {9'd0, light_rsp.red[7:3], light_rsp.green[7:3],
                                           light_rsp.blue[7:3]};
      pseg_pkg::FmtRgb565: packed_value = {8'd0, light_rsp.red[7:3], light_rsp.green[7:3],
                                           1'b0, light_rsp.blue[7:3]};
      pseg_pkg::FmtRgb888: packed_value = {light_rsp.red, light_rsp.green, light_rsp.blue};
      default:             packed_value = '0;
    endcase
  end

  // distance: squares from the read data, then sum
  always_comb begin
    diff[0] = $signed({1'b0, rdata_q[23:16]}) - $signed({1'b0, lit_q[0]});
    diff[1] = $signed({1'b0, rdata_q[15:8]})  - $signed({1'b0, lit_q[1]});
    diff[2] = $signed({1'b0, rdata_q[7:0]})   - $signed({1'b0, lit_q[2]});
    for (int i = 0; i < 3; i++) begin
      sqr[i] = diff[i] * diff[i];
    end
  end

  assign dist_sum = 18'(sq_q[0]) + 18'(sq_q[1]) + 18'(sq_q[2]);

  always_comb begin
    state_d      = state_q;
    scan_idx_d   = scan_idx_q;
    stop_idx_d   = stop_idx_q;
    res_valid_d  = 1'b0;
    res_value_d  = '0;
    res_status_d = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (accept && operation_i == pseg_pkg::OpQuery) begin
          if (level_ok) begin
            state_d = SLight;
          end else begin
            res_valid_d  = 1'b1;
            res_status_d = 1'b1;
          end
        end
      end
      SLight: begin
        if (light_rsp.done) begin
          if (output_format_q != pseg_pkg::FmtIndex) begin
            res_valid_d = 1'b1;
            res_value_d = packed_value;
            state_d     = SIdle;
          end else if (search_empty) begin
            res_valid_d = 1'b1;
            res_value_d = {16'd0, pseg_pkg::EmptySearchIndex};
            state_d     = SIdle;
          end else begin
            scan_idx_d = dest_base_q;
            stop_idx_d = search_stop;
            state_d    = SScan;
          end
        end
      end
      SScan: begin
        if (scan_idx_q == stop_idx_q) begin
          state_d = SDrain;
        end else begin
          scan_idx_d = scan_idx_q + 8'd1;
        end
      end
      SDrain: begin
        if (!p1_v_q && !p2_v_q) begin
          res_valid_d = 1'b1;
          res_value_d = {16'd0, best_q};
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shade_cnt_q     <= pseg_pkg::ResetNumShades;
      dest_base_q     <= pseg_pkg::ResetDestBase;
      dest_range_q    <= pseg_pkg::ResetDestRange;
      output_format_q <= pseg_pkg::FmtIndex;
      state_q         <= SIdle;
      scan_idx_q      <= '0;
      stop_idx_q      <= '0;
      p1_v_q          <= 1'b0;
      p2_v_q          <= 1'b0;
      found_q         <= 1'b0;
      res_valid_q     <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          pseg_pkg::CfgNumShades:    shade_cnt_q     <= cfg_data_i;
          pseg_pkg::CfgDestBase:     dest_base_q     <= cfg_data_i[7:0];
          pseg_pkg::CfgDestRange:    dest_range_q    <= cfg_data_i;
          pseg_pkg::CfgOutputFormat: output_format_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      state_q     <= state_d;
      scan_idx_q  <= scan_idx_d;
      stop_idx_q  <= stop_idx_d;
      p1_v_q      <= rd_en;
      p2_v_q      <= p1_v_q;
      res_valid_q <= res_valid_d;
      if (state_q == SLight) begin
        found_q <= 1'b0;
      end else if (p2_v_q) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SLight && light_rsp.done) begin
      lit_q[0] <= light_rsp.red;
      lit_q[1] <= light_rsp.green;
      lit_q[2] <= light_rsp.blue;
    end
    p1_idx_q <= scan_idx_q;
    p2_idx_q <= p1_idx_q;
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= sqr[i][15:0];
    end
    if (p2_v_q && (!found_q || dist_sum < best_d_q)) begin
      best_d_q <= dist_sum;
      best_q   <= p2_idx_q;
    end
    if (res_valid_d) begin
      res_value_q  <= res_value_d;
      res_status_q <= res_status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[AddrW'(palette_index_i)] <= {red_i, green_i, blue_i};
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign result_valid_o = res_valid_q;
  assign entry_value_o  = res_value_q;
  assign status_o       = res_status_q;

endmodule

`default_nettype wire

// ===== test/palette_shade_entry_generator_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for palette_shade_entry_generator: palette loads, lit-color
// queries in all four output formats, register sweeps. Depends on pseg_pkg and the RTL.

module palette_shade_entry_generator_tb;

  localparam int SettleCycles = 20;
  localparam int DrainCycles  = 300;
  localparam int CycleLimit   = 1_000_000;

  typedef struct packed {
    logic [23:0] entry_value;
    logic        status;
  } shade_entry_t;

  // Tracks palette and registers, predicts one entry per query.
  class shade_entry_scoreboard;
    logic [23:0]                  palette [256];
    logic [pseg_pkg::ShadesW-1:0] shade_cnt;
    logic [7:0]                   dest_base;
    logic [pseg_pkg::ShadesW-1:0] dest_range;
    logic [1:0]                   output_format;
    shade_entry_t                 pending [$];
    int                           mismatch_count;
    int                           results_checked;
    int                           loads_seen;
    int                           queries_seen;

    function new();
      shade_cnt       = pseg_pkg::ResetNumShades;
      dest_base       = pseg_pkg::ResetDestBase;
      dest_range      = pseg_pkg::ResetDestRange;
      output_format   = pseg_pkg::FmtIndex;
      mismatch_count  = 0;
      results_checked = 0;
      loads_seen      = 0;
      queries_seen    = 0;
    endfunction

    function void set_reg(logic [pseg_pkg::CfgIdxW-1:0] idx,
                          logic [pseg_pkg::CfgDataW-1:0] data);
      case (idx)
        pseg_pkg::CfgNumShades:    shade_cnt = data;
        pseg_pkg::CfgDestBase:     dest_base = data[7:0];
        pseg_pkg::CfgDestRange:    dest_range = data;
        pseg_pkg::CfgOutputFormat: output_format = data[1:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] light_channel(logic [7:0] c, logic [7:0] s);
      int unsigned cc, ss, tt;
      cc = c;
      ss = s;
      tt = shade_cnt;
      if (4 * ss < 3 * tt) return 8'((4 * ss * cc) / (3 * tt));
      return 8'(cc + ((4 * ss - 3 * tt) * (255 - cc)) / tt);
    endfunction

    function logic [23:0] nearest_entry(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned best_dist, sq_dist;
      int          dr, dg, db, n;
      logic [7:0]  best;
      bit          found;
      best = pseg_pkg::EmptySearchIndex;
      best_dist = 0;
      found = 0;
      for (n = int'(dest_base);
           n < int'(dest_base) + int'(dest_range) && n <= pseg_pkg::SearchLimit;
           n++) begin
        dr = int'(palette[n][23:16]) - int'(r);
        dg = int'(palette[n][15:8]) - int'(g);
        db = int'(palette[n][7:0]) - int'(b);
        sq_dist = dr * dr + dg * dg + db * db;
        if (!found || sq_dist < best_dist) begin
          found = 1;
          best_dist = sq_dist;
          best = 8'(n);
        end
      end
      return {16'b0, best};
    endfunction

    function void note_item(logic op, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b, logic [7:0] s);
      shade_entry_t exp;
      logic [7:0]   lr, lg, lb;
      if (op == pseg_pkg::OpLoad) begin
        palette[idx] = {r, g, b};
        loads_seen++;
        return;
      end
      queries_seen++;
      exp.status = 1'b0;
      if (pseg_pkg::ShadesW'(s) >= shade_cnt) begin
        exp.entry_value = '0;
        exp.status = 1'b1;
      end else begin
        lr = light_channel(r, s);
        lg = light_channel(g, s);
        lb = light_channel(b, s);
        case (output_format)
          pseg_pkg::FmtIndex:  exp.entry_value = nearest_entry(lr, lg, lb);
          pseg_pkg::FmtRgb555: exp.entry_value = {9'b0, lr[7:3], lg[7:3], lb[7:3]};
          pseg_pkg::FmtRgb565: exp.entry_value = {8'b0, lr[7:3], lg[7:3], 1'b0, lb[7:3]};
          default:             exp.entry_value = {lr, lg, lb};
        endcase
      end
      pending.push_back(exp);
    endfunction

    function void check_entry(logic [23:0] value, logic status);
      shade_entry_t exp;
      results_checked++;
      if (pending.size() == 0) begin
        $error("unexpected result: entry_value %0h status %0b", value, status);
        mismatch_count++;
        return;
      end
      exp = pending.pop_front();
      if (value !== exp.entry_value) begin
        $error("entry_value mismatch: expected %0h actual %0h", exp.entry_value, value);
        mismatch_count++;
      end
      if (status !== exp.status) begin
        $error("status mismatch: expected %0b actual %0b", exp.status, status);
        mismatch_count++;
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          operation_i = pseg_pkg::OpLoad;
  logic [7:0]                    palette_index_i = '0;
  logic [7:0]                    red_i = '0;
  logic [7:0]                    green_i = '0;
  logic [7:0]                    blue_i = '0;
  logic [7:0]                    shade_level_i = '0;
  logic                          result_valid_o;
  logic [23:0]                   entry_value_o;
  logic                          status_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [pseg_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [pseg_pkg::CfgDataW-1:0] cfg_data_i = '0;

  shade_entry_scoreboard sb;
  int sender_idle_pct = 0;
  int cycle_count = 0;
  int settings_used = 0;

  palette_shade_entry_generator DUT (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .palette_index_i, .red_i, .green_i,
    .blue_i, .shade_level_i, .result_valid_o, .entry_value_o, .status_o, .cfg_valid_i,
    .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_entry(entry_value_o, status_o);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("palette_shade_entry_generator_tb failed");
      $finish;
    end
  end

  task automatic send_item(logic op, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                           logic [7:0] b, logic [7:0] s);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    operation_i <= op;
    palette_index_i <= idx;
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    shade_level_i <= s;
    do @(posedge clk_i); while (busy);
    sb.note_item(op, idx, r, g, b, s);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [pseg_pkg::CfgIdxW-1:0] idx,
                           logic [pseg_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
  endtask

  task automatic program_registers(logic [8:0] shades, logic [7:0] base, logic [8:0] span,
                                   logic [1:0] fmt);
    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);
    write_reg(pseg_pkg::CfgNumShades, shades);
    write_reg(pseg_pkg::CfgDestBase, 9'(base));
    write_reg(pseg_pkg::CfgDestRange, span);
    write_reg(pseg_pkg::CfgOutputFormat, 9'(fmt));
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic run_random_items(int count);
    logic [7:0] level;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) begin
        send_item(pseg_pkg::OpLoad, 8'($urandom_range(255)), pick_channel(), pick_channel(),
                  pick_channel(), 8'($urandom_range(255)));
      end else begin
        if ($urandom_range(99) < 12) level = 8'($urandom_range(255));
        else level = 8'($urandom_range(int'(sb.shade_cnt) - 1));
        send_item(pseg_pkg::OpQuery, 8'($urandom_range(255)), pick_channel(), pick_channel(),
                  pick_channel(), level);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: small palette with a duplicate entry for the tie rule.
    program_registers(9'd4, 8'd0, 9'd4, pseg_pkg::FmtIndex);
    send_item(pseg_pkg::OpLoad, 8'd0, 8'h00, 8'h00, 8'h00, 8'd0);
    send_item(pseg_pkg::OpLoad, 8'd1, 8'hff, 8'hff, 8'hff, 8'hff);
    send_item(pseg_pkg::OpLoad, 8'd2, 8'h7f, 8'h7f, 8'h7f, 8'd0);
    send_item(pseg_pkg::OpLoad, 8'd3, 8'h00, 8'h00, 8'h00, 8'd0);
    send_item(pseg_pkg::OpLoad, 8'd255, 8'hff, 8'hff, 8'hff, 8'd0);
    send_item(pseg_pkg::OpQuery, 8'd0, 8'hff, 8'hff, 8'hff, 8'd0);
    send_item(pseg_pkg::OpQuery, 8'd0, 8'hff, 8'hff, 8'hff, 8'd3);
    send_item(pseg_pkg::OpQuery, 8'd0, 8'h00, 8'h00, 8'h00, 8'd3);
    send_item(pseg_pkg::OpQuery, 8'd0, 8'h80, 8'h80, 8'h80, 8'd2);
    send_item(pseg_pkg::OpQuery, 8'd0, 8'ha5, 8'h5a, 8'hc3, 8'd1);
    send_item(pseg_pkg::OpQuery, 8'd0, 8'h12, 8'h34, 8'h56, 8'd4);
    send_item(pseg_pkg::OpQuery, 8'hff, 8'hff, 8'hff, 8'hff, 8'd255);
    // Scan clipped at the last entry.
    program_registers(9'd256, 8'd255, 9'd256, pseg_pkg::FmtIndex);
    send_item(pseg_pkg::OpQuery, 8'd0, 8'h00, 8'h00, 8'h00, 8'd255);
    send_item(pseg_pkg::OpQuery, 8'd0, 8'hff, 8'h00, 8'h80, 8'd0);
    // Packed formats around the ramp knee.
    program_registers(9'd256, 8'd0, 9'd1, pseg_pkg::FmtRgb555);
    send_item(pseg_pkg::OpQuery, 8'd0, 8'hff, 8'h00, 8'h80, 8'd255);
    send_item(pseg_pkg::OpQuery, 8'd0, 8'hff, 8'h00, 8'h80, 8'd191);
    send_item(pseg_pkg::OpQuery, 8'd0, 8'h5a, 8'ha5, 8'hff, 8'd192);
    program_registers(9'd256, 8'd0, 9'd1, pseg_pkg::FmtRgb565);
    send_item(pseg_pkg::OpQuery, 8'd0, 8'hff, 8'hff, 8'hff, 8'd191);
    send_item(pseg_pkg::OpQuery, 8'd0, 8'h5a, 8'ha5, 8'h00, 8'd200);
    program_registers(9'd256, 8'd0, 9'd1, pseg_pkg::FmtRgb888);
    send_item(pseg_pkg::OpQuery, 8'd0, 8'hff, 8'h00, 8'h80, 8'd128);
    send_item(pseg_pkg::OpQuery, 8'd0, 8'h01, 8'hfe, 8'h7f, 8'd255);

    // Fill the whole palette so every later scan reads written entries.
    for (int i = 0; i < 256; i++)
      send_item(pseg_pkg::OpLoad, 8'(i), pick_channel(), pick_channel(), pick_channel(),
                8'd0);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          program_registers(pseg_pkg::ResetNumShades, pseg_pkg::ResetDestBase,
                            pseg_pkg::ResetDestRange, pseg_pkg::FmtIndex);
          sender_idle_pct = 0;
        end
        1: begin
          program_registers(9'd256, 8'($urandom_range(255)), 9'($urandom_range(1, 256)),
                            pseg_pkg::FmtRgb555);
          sender_idle_pct = 70;
        end
        2: begin
          program_registers(9'd1, 8'd255, 9'd1, pseg_pkg::FmtRgb565);
          sender_idle_pct = 21;
        end
        3: begin
          program_registers(9'($urandom_range(1, 256)), 8'($urandom_range(255)),
                            9'($urandom_range(1, 256)), pseg_pkg::FmtRgb888);
          sender_idle_pct = 0;
        end
        4: begin
          program_registers(9'd200, 8'd128, 9'd200, pseg_pkg::FmtIndex);
          sender_idle_pct = 70;
        end
        default: begin
          program_registers(9'($urandom_range(1, 256)), 8'($urandom_range(255)),
                            9'($urandom_range(1, 256)), 2'($urandom_range(3)));
          sender_idle_pct = 21;
        end
      endcase
      run_random_items(80);
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d palette loads and %0d shade queries over %0d register settings;",
             sb.loads_seen, sb.queries_seen, settings_used);
    $display("%0d results compared, %0d mismatches, %0d still outstanding.",
             sb.results_checked, sb.mismatch_count, sb.pending.size());
    if (sb.mismatch_count == 0 && sb.pending.size() == 0) begin
      $display("palette_shade_entry_generator_tb passed");
    end else begin
      $display("palette_shade_entry_generator_tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/pseg_pkg.sv
sv/pseg_light.sv
sv/palette_shade_entry_generator.sv
test/palette_shade_entry_generator_tb.sv
